// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared constants and types of the interpolator
// Table geometry, field widths, command codes and the divider request and
// response bundles.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_W     = $clog2(FRAC_W + 1);
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int ENTRY_W    = 2 * DATA_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/piecewise_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table lookup with interpolation
// Holds up to MAX_POINTS (x, y) breakpoints in signed Q16.16 and evaluates
// a query by clamping at the ends or by linear interpolation on a segment.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                            Handshake
// request   command point_index point_x point_y query_x      start, busy
// result    result_y                                         result_valid
// config    cfg_data (point_count)                           cfg_write
//
// A load request writes the table; busy stays low.
// An evaluate request holds busy while it steps through the first entry, the
// last entry, 1 to 15 scanned entries, setup, the segment check that starts
// the 16-step serial divider, the divider run with the multiply of its
// quotient, and the add and saturation. A clamp at the first or last
// breakpoint ends busy after that entry's step, an interpolation after the
// add; the result shows in the cycle after the last busy cycle.
// An empty table answers in the cycle after the request and busy stays low.
// The result is shown for one cycle on result_valid; the receiver cannot
// stall. Synchronous reset clears the count, sequencer and result_valid only.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [pli_pkg::INDEX_W-1:0]  point_index,
  input  logic signed [31:0]           point_x,
  input  logic signed [31:0]           point_y,
  input  logic signed [31:0]           query_x,
  input  logic                         cfg_write,
  input  logic [pli_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic signed [31:0]           result_y
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_SETUP,
    ST_CHECK,
    ST_DIV,
    ST_MUL
  } state_t;

  localparam int DW = pli_pkg::DATA_W;
  localparam int FW = pli_pkg::FRAC_W;
  localparam int IW = pli_pkg::IDX_W;

  state_t                         state;
  logic [pli_pkg::COUNT_W-1:0]    point_count;
  logic signed [DW-1:0]           query;
  logic [IW-1:0]                  idx;
  logic signed [DW-1:0]           prev_x;
  logic signed [DW-1:0]           prev_y;
  logic signed [DW-1:0]           cur_x;
  logic signed [DW:0]             num;
  logic signed [DW:0]             den;
  logic signed [DW:0]             dy;
  logic signed [DW+FW+1:0]        prod;

  logic                           accept;
  logic                           load_we;
  logic [pli_pkg::CNT_W-1:0]      n_eff;
  logic [IW-1:0]                  last;
  logic [IW-1:0]                  rd_addr;
  logic [pli_pkg::ENTRY_W-1:0]    rd_data;
  logic signed [DW-1:0]           rd_x;
  logic signed [DW-1:0]           rd_y;
  logic signed [DW+1:0]           sum;
  logic signed [DW-1:0]           sum_sat;
  pli_pkg::div_req_t              div_req;
  pli_pkg::div_rsp_t              div_rsp;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  // drop loads aimed beyond the table
  assign load_we = accept && (command == pli_pkg::CMD_LOAD)
                   && (32'(point_index) < 32'(pli_pkg::MAX_POINTS));

  // a count above the table size acts as the table size
  assign n_eff = (32'(point_count) > 32'(pli_pkg::MAX_POINTS))
                 ? pli_pkg::CNT_W'(pli_pkg::MAX_POINTS)
                 : pli_pkg::CNT_W'(point_count);
  assign last  = IW'(n_eff - 1'b1);

  // read address for the entry consumed in the following state
  always_comb begin
    unique case (state)
      ST_IDLE:  rd_addr = '0;
      ST_FIRST: rd_addr = last;
      ST_LAST:  rd_addr = IW'(1);
      ST_SCAN:  rd_addr = idx + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  pli_ram #(
    .WIDTH (pli_pkg::ENTRY_W),
    .DEPTH (pli_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (IW'(point_index)),
    .wdata ({point_x, point_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_x = rd_data[pli_pkg::ENTRY_W-1:DW];
  assign rd_y = rd_data[DW-1:0];

  assign div_req.start = (state == ST_CHECK) && !den[DW] && (den != '0) && !num[DW];
  assign div_req.num   = num[DW-1:0];
  assign div_req.den   = den[DW-1:0];

  pli_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // y1 + floor(t * dy / 2^16), then clamp to the signed 32-bit range
  assign sum = {{2{prev_y[DW-1]}}, prev_y} + (DW+2)'(prod >>> FW);

  always_comb begin
    if (sum > (DW+2)'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
      sum_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (sum < signed'({{3{1'b1}}, {(DW-1){1'b0}}})) begin
      sum_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sum_sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        point_count <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (command == pli_pkg::CMD_EVAL)) begin
            query <= query_x;
            if (n_eff == '0) begin
              // empty table answers zero at once
              result_y     <= '0;
              result_valid <= 1'b1;
            end else begin
              state <= ST_FIRST;
            end
          end
        end
        ST_FIRST: begin
          // clamp at or below the first breakpoint
          prev_x <= rd_x;
          prev_y <= rd_y;
          if (query <= rd_x) begin
            result_y     <= rd_y;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          // clamp at or above the last breakpoint
          if (query >= rd_x) begin
            result_y     <= rd_y;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            idx   <= IW'(1);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // advance until an x above the query or the last slot
          if ((idx == last) || (rd_x > query)) begin
            cur_x <= rd_x;
            dy    <= {rd_y[DW-1], rd_y} - {prev_y[DW-1], prev_y};
            state <= ST_SETUP;
          end else begin
            prev_x <= rd_x;
            prev_y <= rd_y;
            idx    <= idx + 1'b1;
          end
        end
        ST_SETUP: begin
          num   <= {query[DW-1], query} - {prev_x[DW-1], prev_x};
          den   <= {cur_x[DW-1], cur_x} - {prev_x[DW-1], prev_x};
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          // a degenerate segment holds the left ordinate
          if (div_req.start) begin
            state <= ST_DIV;
          end else begin
            result_y     <= prev_y;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            prod  <= signed'({1'b0, div_rsp.quot}) * dy;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          result_y     <= sum_sat;
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pli_divider.sv =====
// ----------------------------------------------------------------------------
// pli_divider: restoring fraction divider
// Computes floor(num * 2^FRAC_W / den), one quotient bit per cycle,
// saturating to all ones when num is not below den.
// ----------------------------------------------------------------------------
module pli_divider (
  input  logic              clk,
  input  logic              rst,
  input  pli_pkg::div_req_t req,
  output pli_pkg::div_rsp_t rsp
);

  logic [pli_pkg::DATA_W-1:0] rem;
  logic [pli_pkg::DATA_W-1:0] den;
  logic [pli_pkg::FRAC_W-1:0] quot;
  logic [pli_pkg::STEP_W-1:0] steps;
  logic                       ovf;
  logic                       done;
  logic [pli_pkg::DATA_W:0]   shifted;
  logic [pli_pkg::DATA_W:0]   diff;
  logic                       fits;

  // one shared subtract and compare per step
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign fits    = !diff[pli_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem   <= req.num;
        den   <= req.den;
        ovf   <= (req.num >= req.den);
        steps <= pli_pkg::STEP_W'(pli_pkg::FRAC_W);
      end else if (steps != '0) begin
        rem   <= fits ? diff[pli_pkg::DATA_W-1:0] : shifted[pli_pkg::DATA_W-1:0];
        quot  <= {quot[pli_pkg::FRAC_W-2:0], fits};
        steps <= steps - 1'b1;
        done  <= (steps == pli_pkg::STEP_W'(1));
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = ovf ? '1 : quot;

endmodule
